### design/afsk_pkg.sv
// Shared types, constants and the sine ROM generator for the AFSK modulator.
// No dependencies; afsk_ctrl, afsk_dp, afsk_ofifo and the top level refer to it by scoped names.
`default_nettype none

package afsk_pkg;

  // HDLC stuffing threshold: a zero goes in after this many data ones
  localparam int unsigned STUFF_LIMIT = 5;

  // Sample counts per bit period; covers the full range of the per-bit cap
  localparam int unsigned CNT_W = 6;

  // Output buffer
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);
  localparam int unsigned LVL_W     = $clog2(OUT_DEPTH + 1);

  localparam int unsigned FULL_Q15 = 32767;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Register indexes
  localparam logic [1:0] REG_MARK_STEP  = 2'd0;
  localparam logic [1:0] REG_SPACE_STEP = 2'd1;
  localparam logic [1:0] REG_SPB        = 2'd2;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd3;

  localparam logic [31:0] RST_MARK_STEP  = 32'd644245094;
  localparam logic [31:0] RST_SPACE_STEP = 32'd1181116006;
  localparam logic [21:0] RST_SPB        = 22'd436907;
  localparam logic [14:0] RST_AMPLITUDE  = 15'd28000;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // latch an input bit, set up first bit period
    logic calc2;   // set up the stuffed-zero period
    logic toggle;  // NRZI toggle for the stuffed zero
    logic issue;   // start one sample down the pipe
    logic last;    // that sample closes the input word
  } afsk_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic             stuff;
    logic [CNT_W-1:0] n1;
    logic [CNT_W-1:0] n2;
    logic             room;
  } afsk_status_t;

  // round(32767*sin(m*(pi/2)/2^qb)), Q30 odd series up to x^11, capped.
  // Only evaluated at elaboration to build the ROM.
  function automatic logic [14:0] quarter_sine(input int unsigned m, input int unsigned qb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] r;
    int          i;
    x  = (64'(m) * HALF_PI_Q30 + (64'd1 << (qb - 1))) >> qb;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (i = 0; i < 5; i++) begin
      case (i)
        0:       d = ((x2 * t) >> 30) / 110;
        1:       d = ((x2 * t) >> 30) / 72;
        2:       d = ((x2 * t) >> 30) / 42;
        3:       d = ((x2 * t) >> 30) / 20;
        default: d = ((x2 * t) >> 30) / 6;
      endcase
      t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    s = (x * t) >> 30;
    r = (s * 64'(FULL_Q15) + (64'd1 << 29)) >> 30;
    if (r > 64'(FULL_Q15)) begin
      r = 64'(FULL_Q15);
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

### design/afsk_if.sv
// Valid/ready channel interfaces for input bits and output samples.
// No dependencies.
`default_nettype none

interface afsk_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic bit_value;

  modport source (output valid, output cmd, output bit_value, input ready);
  modport sink   (input valid, input cmd, input bit_value, output ready);
endinterface

interface afsk_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

### design/afsk_ctrl.sv
// Sequencer: accept a bit, set up periods, meter samples into the datapath.
// Depends on afsk_pkg.
`default_nettype none

module afsk_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  afsk_pkg::afsk_status_t    st,
  output afsk_pkg::afsk_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC2 = 2'd1;
  localparam logic [1:0] S_EMIT1 = 2'd2;
  localparam logic [1:0] S_EMIT2 = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [afsk_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [afsk_pkg::CNT_W-1:0] cnt_inc;

  assign cnt_inc  = cnt_r + 1'b1;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC2;
        end
      end
      S_CALC2: begin
        cmd.calc2 = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        if (cnt_r == st.n1) begin
          cnt_nxt = '0;
          if (st.stuff) begin
            cmd.toggle = 1'b1;
            state_nxt  = S_EMIT2;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (st.room) begin
          cmd.issue = 1'b1;
          // an empty stuffed period leaves the tag on this one
          cmd.last  = (cnt_inc == st.n1) && !(st.stuff && (st.n2 != '0));
          cnt_nxt   = cnt_inc;
        end
      end
      S_EMIT2: begin
        if (cnt_r == st.n2) begin
          state_nxt = S_IDLE;
        end else if (st.room) begin
          cmd.issue = 1'b1;
          cmd.last  = (cnt_inc == st.n2);
          cnt_nxt   = cnt_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### design/afsk_dp.sv
// Datapath: NRZI/stuffing state, period fraction, phase accumulator,
// sine ROM, amplitude scaling pipeline. Depends on afsk_pkg.
`default_nettype none

module afsk_dp #(
  parameter int unsigned SINE_TABLE_BITS     = 10,
  parameter int unsigned MAX_SAMPLES_PER_BIT = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  afsk_pkg::afsk_cmd_t                 cmd,
  input  wire                                 in_cmd,
  input  wire                                 in_bit,
  input  wire [31:0]                          mark_step,
  input  wire [31:0]                          space_step,
  input  wire [21:0]                          spb,
  input  wire [14:0]                          amp,
  input  wire [afsk_pkg::LVL_W-1:0]           fifo_level,
  output afsk_pkg::afsk_status_t              st,
  output logic                                push,
  output logic signed [15:0]                  push_sample,
  output logic                                push_last
);

  localparam int unsigned QB    = SINE_TABLE_BITS - 2;
  localparam int unsigned QSIZE = 1 << QB;
  localparam logic [6:0]  MAX_N = 7'(MAX_SAMPLES_PER_BIT);

  // quarter-wave ROM, entries 0..QSIZE inclusive
  logic [14:0] sine_rom [QSIZE+1];
  for (genvar k = 0; k <= QSIZE; k++) begin : g_rom
    assign sine_rom[k] = afsk_pkg::quarter_sine(k, QB);
  end

  logic                       tone_r;
  logic [2:0]                 ones_r;
  logic [15:0]                frac_r;
  logic                       stuff_r;
  logic [afsk_pkg::CNT_W-1:0] n1_r, n2_r;
  logic [31:0]                phase_r;

  // bit period setup: one add and a clamp
  logic [15:0]                frac_src;
  logic [22:0]                acc;
  logic [6:0]                 n_raw;
  logic [afsk_pkg::CNT_W-1:0] n_clamp;
  logic [2:0]                 ones_inc;

  assign frac_src = cmd.load ? frac_r : frac_r;
  assign acc      = {7'd0, frac_src} + {1'b0, spb};
  assign n_raw    = acc[22:16];
  assign n_clamp  = (n_raw > MAX_N) ? MAX_N[afsk_pkg::CNT_W-1:0]
                                    : n_raw[afsk_pkg::CNT_W-1:0];
  assign ones_inc = ones_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r  <= 1'b1;
      ones_r  <= '0;
      frac_r  <= '0;
      stuff_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        tone_r <= tone_r ^ ~in_bit;
        frac_r <= acc[15:0];
        if (in_cmd || !in_bit) begin
          ones_r  <= '0;
          stuff_r <= 1'b0;
        end else if (ones_inc >= 3'(afsk_pkg::STUFF_LIMIT)) begin
          ones_r  <= '0;
          stuff_r <= 1'b1;
        end else begin
          ones_r  <= ones_inc;
          stuff_r <= 1'b0;
        end
      end
      if (cmd.calc2 && stuff_r) begin
        frac_r <= acc[15:0];
      end
      if (cmd.toggle) begin
        tone_r <= ~tone_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n1_r <= n_clamp;
    end
    if (cmd.calc2) begin
      n2_r <= stuff_r ? n_clamp : '0;
    end
  end

  // sample pipe: ROM read, multiply, reciprocal estimate, correction at push
  logic [SINE_TABLE_BITS-1:0] addr;
  logic [QB:0]                idx;
  logic                       v1_r, v2_r, v3_r;
  logic                       neg1_r, neg2_r, neg3_r;
  logic                       last1_r, last2_r, last3_r;
  logic [14:0]                rom_q_r;
  logic [29:0]                p2_r, p3_r;
  logic [30:0]                t2;
  logic [15:0]                q3_r;
  logic [30:0]                rem;
  logic                       corr;
  logic [15:0]                mag;

  assign addr = phase_r[31 -: SINE_TABLE_BITS];
  assign idx  = addr[QB] ? ((QB+1)'(QSIZE) - {1'b0, addr[QB-1:0]})
                         : {1'b0, addr[QB-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      if (cmd.issue) begin
        phase_r <= phase_r + (tone_r ? mark_step : space_step);
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign t2 = {1'b0, p2_r} + {16'd0, p2_r[29:15]};

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[idx];
    neg1_r  <= addr[SINE_TABLE_BITS-1];
    last1_r <= cmd.last;
    p2_r    <= 30'(amp) * 30'(rom_q_r);
    neg2_r  <= neg1_r;
    last2_r <= last1_r;
    q3_r    <= t2[30:15];
    p3_r    <= p2_r;
    neg3_r  <= neg2_r;
    last3_r <= last2_r;
  end

  // estimate is exact or one low; remainder test fixes it
  assign rem  = {1'b0, p3_r} + {15'd0, q3_r} - {q3_r, 15'd0};
  assign corr = (rem >= 31'(afsk_pkg::FULL_Q15));
  assign mag  = q3_r + {15'd0, corr};

  assign push        = v3_r;
  assign push_last   = last3_r;
  assign push_sample = neg3_r ? 16'(~mag + 16'd1) : mag;

  logic [afsk_pkg::LVL_W:0] busy;
  assign busy = {1'b0, fifo_level} + (afsk_pkg::LVL_W+1)'(v1_r)
              + (afsk_pkg::LVL_W+1)'(v2_r) + (afsk_pkg::LVL_W+1)'(v3_r);

  assign st.stuff = stuff_r;
  assign st.n1    = n1_r;
  assign st.n2    = n2_r;
  assign st.room  = (busy < (afsk_pkg::LVL_W+1)'(afsk_pkg::OUT_DEPTH));

endmodule

`default_nettype wire

### design/afsk_ofifo.sv
// Output word buffer; drives the result channel.
// Depends on afsk_pkg and afsk_if.
`default_nettype none

module afsk_ofifo (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  input  wire signed [15:0]            push_sample,
  input  wire                          push_last,
  output logic [afsk_pkg::LVL_W-1:0]   level,
  afsk_out_if.source                   out_ch
);

  logic signed [15:0]          smp_mem_r  [afsk_pkg::OUT_DEPTH];
  logic                        last_mem_r [afsk_pkg::OUT_DEPTH];
  logic [afsk_pkg::OUT_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [afsk_pkg::LVL_W-1:0]  level_r;
  logic                        pop;

  assign pop           = out_ch.valid && out_ch.ready;
  assign out_ch.valid  = (level_r != '0);
  assign out_ch.sample = smp_mem_r[rd_ptr_r];
  assign out_ch.last   = last_mem_r[rd_ptr_r];
  assign level         = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      smp_mem_r[wr_ptr_r]  <= push_sample;
      last_mem_r[wr_ptr_r] <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   level_r <= level_r + 1'b1;
        2'b01:   level_r <= level_r - 1'b1;
        default: level_r <= level_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/afsk_nrzi_bit_stuff_modulator.sv
// Top level of the Bell 202 style AFSK modulator with NRZI and bit stuffing.
// Depends on afsk_pkg, afsk_if, afsk_ctrl, afsk_dp, afsk_ofifo.
`default_nettype none

// One input word is one HDLC bit (cmd 0: data bit, stuffed; cmd 1: flag bit,
// not stuffed, clears the ones run). A zero toggles the tone, a one keeps it;
// after five data ones a stuffed zero adds a toggle and one more bit period.
// Each bit period yields floor((fraction + samples_per_bit_fixed) / 2^16)
// samples, capped at MAX_SAMPLES_PER_BIT; sample = amplitude * sin(phase) /
// 32767 truncated toward zero, sine from a quarter-wave ROM of
// 2^(SINE_TABLE_BITS-2)+1 entries. last marks the final sample of a word; a
// word whose periods give no samples produces no output word.
// Sequencing: a bit passes the sequencer's accept and setup steps, issues its n1
// samples one per cycle while the output buffer has room, and ends with a
// period-end step; a stuffed zero adds a second period of n2 samples. The next bit
// is accepted only after the previous one's samples are all issued. Samples pass
// the ROM, multiply and estimate registers into an 8-word output buffer, which
// absorbs sink stalls; issue pauses when buffer plus pipe would overflow.
// Registers (APB, byte address 4*i): 0 mark_phase_step, 1 space_phase_step,
// 2 samples_per_bit_fixed (22 bits), 3 amplitude (15 bits); write only while
// idle. pready is tied high.
module afsk_nrzi_bit_stuff_modulator #(
  parameter int unsigned SINE_TABLE_BITS     = 10,
  parameter int unsigned MAX_SAMPLES_PER_BIT = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  afsk_in_if.sink     in_ch,
  afsk_out_if.source  out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [31:0] mark_step_r;
  logic [31:0] space_step_r;
  logic [21:0] spb_r;
  logic [14:0] amp_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_step_r  <= afsk_pkg::RST_MARK_STEP;
      space_step_r <= afsk_pkg::RST_SPACE_STEP;
      spb_r        <= afsk_pkg::RST_SPB;
      amp_r        <= afsk_pkg::RST_AMPLITUDE;
    end else if (wr_en) begin
      case (reg_idx)
        afsk_pkg::REG_MARK_STEP:  mark_step_r  <= pwdata;
        afsk_pkg::REG_SPACE_STEP: space_step_r <= pwdata;
        afsk_pkg::REG_SPB:        spb_r        <= pwdata[21:0];
        afsk_pkg::REG_AMPLITUDE:  amp_r        <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      afsk_pkg::REG_MARK_STEP:  prdata = mark_step_r;
      afsk_pkg::REG_SPACE_STEP: prdata = space_step_r;
      afsk_pkg::REG_SPB:        prdata = {10'd0, spb_r};
      afsk_pkg::REG_AMPLITUDE:  prdata = {17'd0, amp_r};
      default:                  prdata = '0;
    endcase
  end

  // controller <-> datapath
  afsk_pkg::afsk_cmd_t        cmd;
  afsk_pkg::afsk_status_t     st;
  logic                       push;
  logic signed [15:0]         push_sample;
  logic                       push_last;
  logic [afsk_pkg::LVL_W-1:0] fifo_level;

  afsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  afsk_dp #(
    .SINE_TABLE_BITS     (SINE_TABLE_BITS),
    .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_cmd      (in_ch.cmd),
    .in_bit      (in_ch.bit_value),
    .mark_step   (mark_step_r),
    .space_step  (space_step_r),
    .spb         (spb_r),
    .amp         (amp_r),
    .fifo_level  (fifo_level),
    .st          (st),
    .push        (push),
    .push_sample (push_sample),
    .push_last   (push_last)
  );

  // output buffer decouples sample issue from sink stalls
  afsk_ofifo u_ofifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_sample (push_sample),
    .push_last   (push_last),
    .level       (fifo_level),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

### design/afsk_checker.sv
// Port-level checks for the AFSK modulator, bound to the top level.
// Depends on afsk_nrzi_bit_stuff_modulator and afsk_if.
`default_nettype none

module afsk_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_sample,
  input wire        out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("output word changed while stalled");

  // one bit at a time: accept drops ready for setup
  a_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // reset leaves the buffer empty
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // reset leaves the sequencer ready for a bit
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind afsk_nrzi_bit_stuff_modulator afsk_checker u_afsk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample),
  .out_last   (out_ch.last)
);

`default_nettype wire

### bench/tb_afsk_nrzi_bit_stuff_modulator.sv
// Self-checking bench for the AFSK modulator with NRZI coding and HDLC bit stuffing.
// Depends on afsk_pkg (register indexes), afsk_if (channels) and the design top level.
// Bit words go in through a queue-fed driver; sample words are checked against a predictor.
`default_nettype none

module tb_afsk_nrzi_bit_stuff_modulator;

  // Design parameters, mirrored for the predictor
  localparam int unsigned LUT_BITS  = 10;
  localparam int unsigned QTR_BITS  = LUT_BITS - 2;
  localparam int unsigned PER_CAP   = 32;
  localparam int unsigned STUFF_AT  = 5;
  localparam int          Q15_FULL  = 32767;
  localparam logic [63:0] Q30_UNIT  = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q = 64'd1686629713;

  // Register values after reset
  localparam logic [31:0] DEF_MARK  = 32'd644245094;
  localparam logic [31:0] DEF_SPACE = 32'd1181116006;
  localparam logic [21:0] DEF_SPB   = 22'd436907;
  localparam logic [14:0] DEF_AMP   = 15'd28000;

  localparam logic [7:0] FLAG_OCTET = 8'h7E;

  // Run control
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE      = 100;   // > longest bit (two capped periods) + pipe
  localparam int unsigned HOLD_LEN    = 400;   // sink hold-off, far beyond the 8-word buffer
  localparam int unsigned HOLD_AFTER  = 50;    // words seen before the hold-off starts
  localparam int unsigned MAX_PRINTS  = 40;

  typedef enum logic {KIND_DATA = 1'b0, KIND_FLAG = 1'b1} bit_kind_e;

  typedef struct {
    bit_kind_e kind;
    logic      value;
  } hdlc_bit_t;

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } sample_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  afsk_in_if  in_ch ();
  afsk_out_if out_ch ();

  afsk_nrzi_bit_stuff_modulator #(
    .SINE_TABLE_BITS     (LUT_BITS),
    .MAX_SAMPLES_PER_BIT (PER_CAP)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: register shadows plus the modulator's own state
  // ---------------------------------------------------------------------------
  logic [31:0] mark_cfg;
  logic [31:0] space_cfg;
  logic [21:0] spb_cfg;
  logic [14:0] amp_cfg;

  logic [31:0] phase_acc;
  logic        tone_mark;
  int unsigned ones_run;
  logic [15:0] frac_acc;

  int sine_lut [0:(1 << LUT_BITS) - 1];

  hdlc_bit_t    bit_q[$];      // bits waiting to be offered
  sample_word_t sample_q[$];   // samples predicted, not yet seen

  // Bookkeeping
  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned words_seen  = 0;
  int unsigned bits_taken  = 0;
  int unsigned flag_cnt    = 0;
  int unsigned stuff_cnt   = 0;
  int unsigned silent_cnt  = 0;
  int unsigned setting_cnt = 0;
  int unsigned bits_queued = 0;
  int unsigned max_backlog = 0;
  logic        in_took     = 1'b0;
  logic        no_idle     = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned in_gap      = 0;

  task automatic log_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("[%0d] word %0d: %s", cycle_cnt, words_seen, what);
    end
  endtask

  // round(32767*sin(m*(pi/2)/2^QTR_BITS)) via a Q30 odd series, Horner form.
  // Nested factors are 1 - x^2/((2k)(2k+1)) for k = 5 down to 1.
  function automatic int q15_quarter(input int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] r;
    int          k;
    x  = (64'(m) * HALF_PI_Q + (64'd1 << (QTR_BITS - 1))) >> QTR_BITS;
    x2 = (x * x) >> 30;
    t  = Q30_UNIT;
    for (k = 5; k >= 1; k--) begin
      d = ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
      t = (d >= Q30_UNIT) ? 64'd0 : Q30_UNIT - d;
    end
    s = (x * t) >> 30;
    r = (s * 64'(Q15_FULL) + (64'd1 << 29)) >> 30;
    if (r > 64'(Q15_FULL)) begin
      r = 64'(Q15_FULL);
    end
    return int'(r);
  endfunction

  function automatic void build_sine_lut();
    int unsigned qsize;
    int unsigned quad;
    int unsigned rem;
    int          v;
    int unsigned k;
    qsize = 1 << QTR_BITS;
    for (k = 0; k < (1 << LUT_BITS); k++) begin
      quad = (k >> QTR_BITS) & 3;
      rem  = k & (qsize - 1);
      v    = quad[0] ? q15_quarter(qsize - rem) : q15_quarter(rem);
      sine_lut[k] = quad[1] ? -v : v;
    end
  endfunction

  // One bit period: advance the 16.16 fraction, emit its samples
  function automatic int unsigned emit_bit_period();
    logic [31:0]  acc;
    logic [31:0]  step;
    int unsigned  n;
    int unsigned  i;
    int           s;
    sample_word_t w;
    acc      = 32'(frac_acc) + 32'(spb_cfg);
    frac_acc = acc[15:0];
    n        = acc[31:16];
    if (n > PER_CAP) begin
      n = PER_CAP;   // excess dropped, fraction kept
    end
    step = tone_mark ? mark_cfg : space_cfg;
    for (i = 0; i < n; i++) begin
      s = int'(amp_cfg) * sine_lut[phase_acc[31 -: LUT_BITS]] / Q15_FULL;
      w.sample = s[15:0];
      w.last   = 1'b0;
      sample_q.push_back(w);
      phase_acc = phase_acc + step;
    end
    return n;
  endfunction

  // NRZI + stuffing for one accepted bit word
  function automatic void predict_bit(input bit_kind_e kind, input logic value);
    int unsigned cnt;
    if (!value) begin
      tone_mark = ~tone_mark;
    end
    cnt = emit_bit_period();
    if (kind == KIND_FLAG || !value) begin
      ones_run = 0;
    end else begin
      ones_run++;
      if (ones_run >= STUFF_AT) begin
        // stuffed zero: extra toggle and period, samples follow in the same word
        tone_mark = ~tone_mark;
        cnt += emit_bit_period();
        ones_run = 0;
        stuff_cnt++;
      end
    end
    if (cnt > 0) begin
      sample_q[sample_q.size() - 1].last = 1'b1;
    end else begin
      silent_cnt++;
    end
    if (kind == KIND_FLAG) begin
      flag_cnt++;
    end
    bits_taken++;
  endfunction

  // Idle length for either side: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Posedge: timeout, bit acceptance into the predictor, sample check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sample_check
    sample_word_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still expected",
               cycle_cnt, sample_q.size());
      $display("afsk_nrzi_bit_stuff_modulator: mismatch");
      $finish;
    end else if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) begin
        predict_bit(bit_kind_e'(in_ch.cmd), in_ch.bit_value);
      end
      if (sample_q.size() > max_backlog) begin
        max_backlog = sample_q.size();
      end
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (sample_q.size() == 0) begin
          log_mismatch($sformatf("unexpected word sample=%0d last=%0b",
                                 out_ch.sample, out_ch.last));
        end else begin
          want = sample_q.pop_front();
          if (out_ch.sample !== want.sample) begin
            log_mismatch($sformatf("sample %0d, want %0d",
                                   out_ch.sample, $signed(want.sample)));
          end
          if (out_ch.last !== want.last) begin
            log_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Negedge driver: offers the next bit word after a random gap; valid held
  // high until the word is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : bit_driver
    logic      offer;
    hdlc_bit_t nxt;
    offer = in_ch.valid && !in_took;
    if (rst_n && !offer) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (bit_q.size() > 0) begin
        nxt = bit_q.pop_front();
        in_ch.cmd       <= nxt.kind;
        in_ch.bit_value <= nxt.value;
        offer  = 1'b1;
        in_gap = idle_len();
      end
    end
    in_ch.valid <= offer;
  end

  // ---------------------------------------------------------------------------
  // Negedge sink ready: random stalls, plus one long hold-off once traffic is
  // flowing so the output buffer fills and the input side backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sink_ready
    logic rdy;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && words_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      rdy       = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      rdy        = 1'b1;
      stall_left = idle_len();
    end
    out_ch.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_bit(input bit_kind_e kind, input logic value);
    hdlc_bit_t b;
    b.kind  = kind;
    b.value = value;
    bit_q.push_back(b);
    bits_queued++;
  endtask

  // HDLC sends LSB first
  task automatic queue_octet(input logic [7:0] v, input bit_kind_e kind, input int unsigned nbits);
    int unsigned i;
    for (i = 0; i < nbits; i++) begin
      queue_bit(kind, v[i]);
    end
  endtask

  task automatic queue_frame();
    int unsigned nbytes;
    logic [7:0]  v;
    queue_octet(FLAG_OCTET, KIND_FLAG, 8);
    nbytes = $urandom_range(1, 2);
    repeat (nbytes) begin
      case ($urandom_range(0, 3))
        0: begin
          v = 8'hFF;                              // forces stuffing
        end
        1: begin
          v = 8'hFF ^ (8'h01 << $urandom_range(0, 7));
        end
        default: begin
          v = 8'($urandom);
        end
      endcase
      queue_octet(v, KIND_DATA, 8);
    end
    queue_octet(FLAG_OCTET, KIND_FLAG, 8);
  endtask

  // Wait until the block has drained, then let any silent bit finish
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (bit_q.size() != 0 || in_ch.valid || sample_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // APB write: setup, access, idle; shadow updated with width masking
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      afsk_pkg::REG_MARK_STEP:  mark_cfg  = val;
      afsk_pkg::REG_SPACE_STEP: space_cfg = val;
      afsk_pkg::REG_SPB:        spb_cfg   = val[21:0];
      default:                  amp_cfg   = val[14:0];
    endcase
  endtask

  task automatic set_config(input logic [31:0] mark, input logic [31:0] space,
                            input logic [31:0] spb, input logic [31:0] amp);
    write_reg(afsk_pkg::REG_MARK_STEP, mark);
    write_reg(afsk_pkg::REG_SPACE_STEP, space);
    write_reg(afsk_pkg::REG_SPB, spb);
    write_reg(afsk_pkg::REG_AMPLITUDE, amp);
    setting_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph;
    int unsigned goal;
    logic [31:0] spb_pick;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = 1'b0;
    in_ch.bit_value = 1'b0;
    out_ch.ready    = 1'b0;

    build_sine_lut();
    mark_cfg  = DEF_MARK;
    space_cfg = DEF_SPACE;
    spb_cfg   = DEF_SPB;
    amp_cfg   = DEF_AMP;
    phase_acc = '0;
    tone_mark = 1'b1;
    ones_run  = 0;
    frac_acc  = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: both kinds and values, stuffing, flag and zero breaking runs.
    // The long sink hold-off lands in this stretch.
    setting_cnt++;
    queue_bit(KIND_DATA, 1'b0);
    queue_bit(KIND_DATA, 1'b1);
    queue_bit(KIND_FLAG, 1'b0);
    queue_bit(KIND_FLAG, 1'b1);
    repeat (5) queue_bit(KIND_DATA, 1'b1);      // stuffed zero after the fifth
    repeat (4) queue_bit(KIND_DATA, 1'b1);
    queue_bit(KIND_FLAG, 1'b1);                 // flag clears the run, no stuffing
    repeat (4) queue_bit(KIND_DATA, 1'b1);
    queue_bit(KIND_DATA, 1'b0);                 // zero clears the run
    repeat (6) queue_bit(KIND_DATA, 1'b1);      // stuff, then a fresh run
    wait_drained();

    // One sample per bit, full amplitude, extreme steps
    set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'd65536, 32'd32767);
    repeat (5) queue_bit(KIND_DATA, 1'b1);
    queue_bit(KIND_DATA, 1'b0);
    queue_bit(KIND_FLAG, 1'b1);
    wait_drained();

    // Fast bit rate: all-ones writes mask down; every period hits the cap
    set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_bit(KIND_DATA, 1'b0);
    repeat (5) queue_bit(KIND_DATA, 1'b1);
    queue_bit(KIND_FLAG, 1'b0);
    wait_drained();

    // Zero amplitude
    set_config(DEF_MARK, DEF_SPACE, 32'd2097152, 32'd0);
    queue_bit(KIND_DATA, 1'b1);
    queue_bit(KIND_DATA, 1'b0);
    queue_bit(KIND_FLAG, 1'b1);
    wait_drained();

    // Slow bit rate: many bits give no samples at all
    set_config(32'($urandom), 32'($urandom), 32'($urandom_range(8000, 40000)),
               32'($urandom_range(0, 32767)));
    repeat (10) queue_bit(bit_kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    queue_octet(8'hFF, KIND_DATA, 8);
    wait_drained();

    // Random settings, mostly framed traffic with some noise and cut-off flags
    for (ph = 0; ph < 2; ph++) begin
      no_idle  = (ph == 1);
      spb_pick = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(65536, 600000))
                                            : 32'($urandom_range(600000, 2097152));
      set_config(32'($urandom), 32'($urandom), spb_pick, 32'($urandom_range(0, 32767)));
      goal = bits_queued + 10;
      while (bits_queued < goal) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            repeat ($urandom_range(2, 6)) begin
              queue_bit(bit_kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
          end
          3, 4: begin
            queue_octet(FLAG_OCTET, KIND_FLAG, $urandom_range(1, 7));
          end
          default: begin
            queue_frame();
          end
        endcase
      end
      wait_drained();
    end
    no_idle = 1'b0;

    $display("bits %0d (flags %0d, stuffed zeros %0d, silent %0d), samples %0d",
             bits_taken, flag_cnt, stuff_cnt, silent_cnt, words_seen);
    $display("%0d register settings, peak backlog %0d samples, sink hold-off %0d cycles",
             setting_cnt, max_backlog, HOLD_LEN);
    if (err_cnt == 0) begin
      $display("afsk_nrzi_bit_stuff_modulator: match");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("afsk_nrzi_bit_stuff_modulator: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
